// ----- sv/lbse_pkg.sv -----
// ----------------------------------------------------------------------------
// lbse_pkg
// Shared types and constants for the LED blink setting encoder.
// ----------------------------------------------------------------------------
package lbse_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam logic [0:0] CSR_ENABLED     = 1'b0;
   localparam logic [0:0] CSR_LINEAR_RAMP = 1'b1;

   // driver register numbers
   localparam logic [2:0] REG_SCALE  = 3'd0;
   localparam logic [2:0] REG_PERIOD = 3'd1;
   localparam logic [2:0] REG_DUTY   = 3'd2;
   localparam logic [2:0] REG_MODE   = 3'd4;
   localparam logic [2:0] REG_RAMP   = 3'd5;

   localparam logic [7:0] REG0_BASE  = 8'h18;
   localparam logic [7:0] TIMER_MODE = 8'hAA;

   // period code limits
   localparam logic [15:0] PERIOD_MAX      = 16'd16384;
   localparam logic [6:0]  PERIOD_CODE_MAX = 7'd126;
   localparam logic [15:0] PERIOD_MIN      = 16'd256;
   localparam logic [15:0] PERIOD_ONE      = 16'd448;
   localparam logic [15:0] PERIOD_OFFSET   = 16'd384;

   // ramp limits
   localparam logic [15:0] RAMP_MAX    = 16'd7680;
   localparam logic [12:0] RAMP_BAND2  = 13'd3840;
   localparam logic [12:0] RAMP_BAND1  = 13'd1920;
   localparam logic [12:0] RAMP_SHORT  = 13'd248;

   // one classified item
   typedef struct packed {
      logic [1:0] scale;
      logic [7:0] period_byte;
      logic [7:0] duty;
      logic [7:0] ramp_byte;
   } lbse_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } lbse_qstat_type;

endpackage

// ----- sv/led_blink_setting_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// led_blink_setting_encoder_unit
// Turns a blink request into five LED driver register writes.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low. When enabled,
// it is encoded in the same cycle and queued; the write sequencer then
// presents five writes (registers 0, 1, 2, 5, 4) on consecutive cycles, each
// marked by rsp_valid for one cycle, the fifth with rsp_last_write. When the
// sequencer is idle, the item passes through the queue memory and the queue's
// read register before its first write appears. While items wait, writes run
// gap-free at one write per cycle; the queue holds QUEUE_DEPTH items and busy
// rises when it is full (and during reset). The receiver cannot stall writes.
// Items accepted while disabled produce no writes.
module led_blink_setting_encoder_unit import lbse_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_period_ms,
   input  logic [7:0]  req_duty,
   input  logic [15:0] req_rise_ms,
   input  logic [15:0] req_fall_ms,
   output logic        rsp_valid,
   output logic [2:0]  rsp_reg_index,
   output logic [7:0]  rsp_reg_data,
   output logic        rsp_last_write,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [0:0]  csr_wdata
);

   logic           enabled_ff;
   logic           enabled_in;
   logic           linear_ramp_ff;
   logic           linear_ramp_in;
   logic           accept;
   logic           push;
   logic           pop;
   lbse_entry_type wr_entry;
   lbse_entry_type rd_entry;
   lbse_qstat_type qstat;

   always_comb begin
      enabled_in     = enabled_ff;
      linear_ramp_in = linear_ramp_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENABLED:     enabled_in     = csr_wdata[0];
            CSR_LINEAR_RAMP: linear_ramp_in = csr_wdata[0];
            default: begin
               enabled_in     = enabled_ff;
               linear_ramp_in = linear_ramp_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b0;
         linear_ramp_ff <= 1'b0;
      end else begin
         enabled_ff     <= enabled_in;
         linear_ramp_ff <= linear_ramp_in;
      end
   end

   assign busy   = reset | qstat.full;
   assign accept = start & ~busy;

   lbse_front u_front (
      .enabled     (enabled_ff),
      .linear_ramp (linear_ramp_ff),
      .accept      (accept),
      .period_ms   (req_period_ms),
      .duty        (req_duty),
      .rise_ms     (req_rise_ms),
      .fall_ms     (req_fall_ms),
      .push        (push),
      .entry       (wr_entry)
   );

   lbse_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_entry),
      .pop     (pop),
      .rd_data (rd_entry),
      .stat    (qstat)
   );

   lbse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .entry      (rd_entry),
      .pop        (pop),
      .valid      (rsp_valid),
      .reg_index  (rsp_reg_index),
      .reg_data   (rsp_reg_data),
      .last_write (rsp_last_write)
   );

   // a write sequence never breaks off before its last write
   a_seq_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_write |=> rsp_valid)
      else $error("write sequence interrupted");

   // register 0 always keeps the fixed base bits
   a_reg0_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_index == REG_SCALE |-> rsp_reg_data[4:0] == REG0_BASE[4:0])
      else $error("reg0 base bits wrong");

   // the mode write closes each item and carries the timer mode byte
   a_mode_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_index == REG_MODE |-> rsp_last_write && rsp_reg_data == TIMER_MODE)
      else $error("mode write not last or wrong data");

   // a queued item is always picked up by an idle sequencer
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !qstat.empty && !rsp_valid |-> pop)
      else $error("sequencer idle with queued item");

endmodule

// ----- sv/lbse_front.sv -----
// ----------------------------------------------------------------------------
// lbse_front
// Accepts requests and turns them into register codes for the queue.
// ----------------------------------------------------------------------------
module lbse_front import lbse_pkg::*; (
   input  logic                 enabled,
   input  logic                 linear_ramp,
   input  logic                 accept,
   input  logic [15:0]          period_ms,
   input  logic [7:0]           duty,
   input  logic [15:0]          rise_ms,
   input  logic [15:0]          fall_ms,
   output logic                 push,
   output lbse_entry_type       entry
);

   logic [13:0] per_adj;
   logic [6:0]  per_code;
   logic [12:0] up_c;
   logic [12:0] dn_c;
   logic [12:0] up_f;
   logic [12:0] dn_f;
   logic [12:0] step;
   logic [12:0] half_mask;
   logic [3:0]  sh;
   logic [1:0]  scale;
   logic [12:0] up_q;
   logic [12:0] dn_q;
   logic        up_half;
   logic        dn_half;
   logic        up_low;
   logic [3:0]  rise_code;
   logic [3:0]  fall_code;
   logic        both_zero;

   assign push = accept & enabled;

   // period code
   always_comb begin
      per_adj = 14'(period_ms - PERIOD_OFFSET);
      if (period_ms > PERIOD_MAX) begin
         per_code = PERIOD_CODE_MAX;
      end else if (period_ms < PERIOD_MIN) begin
         per_code = 7'd0;
      end else if (period_ms < PERIOD_ONE) begin
         per_code = 7'd1;
      end else begin
         per_code = per_adj[13:7] + (per_adj[6] ? 7'd2 : 7'd1);
      end
   end

   // ramp codes: band pick, floor, then shift and round
   always_comb begin
      both_zero = (rise_ms == 16'd0) && (fall_ms == 16'd0);
      up_c = (rise_ms > RAMP_MAX) ? RAMP_MAX[12:0] : rise_ms[12:0];
      dn_c = (fall_ms > RAMP_MAX) ? RAMP_MAX[12:0] : fall_ms[12:0];
      if ((up_c < RAMP_SHORT) && (dn_c < RAMP_SHORT)) begin
         sh = 4'd4;
         scale = 2'd3;
      end else if ((up_c > RAMP_BAND2) || (dn_c > RAMP_BAND2)) begin
         sh = 4'd9;
         scale = 2'd2;
      end else if ((up_c > RAMP_BAND1) || (dn_c > RAMP_BAND1)) begin
         sh = 4'd8;
         scale = 2'd1;
      end else begin
         sh = 4'd7;
         scale = 2'd0;
      end
      step = 13'd1 << sh;
      half_mask = (step >> 1) - 13'd1;
      up_f = (up_c < step) ? step : up_c;
      dn_f = (dn_c < step) ? step : dn_c;
      up_q = up_f >> sh;
      dn_q = dn_f >> sh;
      up_half = |(up_f & (step >> 1));
      dn_half = |(dn_f & (step >> 1));
      up_low = |(up_f & half_mask);
      fall_code = dn_q[3:0] + {3'd0, dn_half};
      rise_code = up_q[3:0] + {3'd0, up_half & up_low};
      if (both_zero) begin
         fall_code = 4'd0;
         rise_code = 4'd0;
         scale = 2'd0;
      end
   end

   assign entry.scale       = scale;
   assign entry.period_byte = {linear_ramp, per_code};
   assign entry.duty        = duty;
   assign entry.ramp_byte   = {fall_code, rise_code};

endmodule

// ----- sv/lbse_queue.sv -----
// ----------------------------------------------------------------------------
// lbse_queue
// Small FIFO of classified items with a registered read port.
// ----------------------------------------------------------------------------
module lbse_queue import lbse_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  lbse_entry_type wr_data,
   input  logic           pop,
   output lbse_entry_type rd_data,
   output lbse_qstat_type stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   lbse_entry_type mem [DEPTH];
   lbse_entry_type rd_data_ff;
   logic [AW-1:0]  wr_ptr_ff;
   logic [AW-1:0]  wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff;
   logic [AW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data    = rd_data_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

endmodule

// ----- sv/lbse_back.sv -----
// ----------------------------------------------------------------------------
// lbse_back
// Write sequencer: plays one queued item out as five register writes.
// ----------------------------------------------------------------------------
module lbse_back import lbse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  lbse_qstat_type qstat,
   input  lbse_entry_type entry,
   output logic           pop,
   output logic           valid,
   output logic [2:0]     reg_index,
   output logic [7:0]     reg_data,
   output logic           last_write
);

   localparam logic [2:0] BEAT_SCALE  = 3'd0;
   localparam logic [2:0] BEAT_PERIOD = 3'd1;
   localparam logic [2:0] BEAT_DUTY   = 3'd2;
   localparam logic [2:0] BEAT_RAMP   = 3'd3;
   localparam logic [2:0] BEAT_MODE   = 3'd4;

   logic       active_ff;
   logic       active_in;
   logic [2:0] beat_ff;
   logic [2:0] beat_in;

   // fetch the next item during the final write so writes run gap-free
   assign pop = !qstat.empty && (!active_ff || (beat_ff == BEAT_MODE));

   always_comb begin
      active_in = active_ff;
      beat_in   = beat_ff;
      if (pop) begin
         active_in = 1'b1;
         beat_in   = BEAT_SCALE;
      end else if (active_ff) begin
         if (beat_ff == BEAT_MODE) begin
            active_in = 1'b0;
            beat_in   = BEAT_SCALE;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         beat_ff   <= BEAT_SCALE;
      end else begin
         active_ff <= active_in;
         beat_ff   <= beat_in;
      end
   end

   always_comb begin
      case (beat_ff)
         BEAT_SCALE: begin
            reg_index = REG_SCALE;
            reg_data  = REG0_BASE | {1'b0, entry.scale, 5'd0};
         end
         BEAT_PERIOD: begin
            reg_index = REG_PERIOD;
            reg_data  = entry.period_byte;
         end
         BEAT_DUTY: begin
            reg_index = REG_DUTY;
            reg_data  = entry.duty;
         end
         BEAT_RAMP: begin
            reg_index = REG_RAMP;
            reg_data  = entry.ramp_byte;
         end
         BEAT_MODE: begin
            reg_index = REG_MODE;
            reg_data  = TIMER_MODE;
         end
         default: begin
            reg_index = REG_MODE;
            reg_data  = TIMER_MODE;
         end
      endcase
   end

   assign valid      = active_ff;
   assign last_write = active_ff && (beat_ff == BEAT_MODE);

endmodule
